[sv/qco_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_pkg: shared types and constants for the quad corner ordering block
// Holds the corner count, corner index type, half-plane codes and the table
// of corner pairs whose angles are compared.
// ----------------------------------------------------------------------------
package qco_pkg;

    localparam int NCORNERS = 4;
    localparam int NPAIRS   = 6;
    localparam int IDX_W    = 2;

    typedef logic [IDX_W-1:0] idx_t;

    // Half-plane of a direction; codes sort in angle order over (-pi, pi]
    typedef logic [1:0] half_t;
    localparam half_t HALF_LOWER = 2'd0;  // angle in (-pi, 0)
    localparam half_t HALF_UPPER = 2'd1;  // angle in [0, pi)
    localparam half_t HALF_PI    = 2'd2;  // straight left, angle pi

    // Unordered corner pairs (i < j)
    localparam idx_t PAIR_I [NPAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam idx_t PAIR_J [NPAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage
`default_nettype wire

[sv/qco_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_if: valid/ready channels of the quad corner ordering block
// qco_quad_if carries the reference point and the four raw corners,
// qco_result_if the reference point and the four ordered corners.
// ----------------------------------------------------------------------------
interface qco_quad_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ref_x;
    logic signed [COORD_WIDTH-1:0] ref_y;
    logic signed [COORD_WIDTH-1:0] corner_a_x;
    logic signed [COORD_WIDTH-1:0] corner_a_y;
    logic signed [COORD_WIDTH-1:0] corner_b_x;
    logic signed [COORD_WIDTH-1:0] corner_b_y;
    logic signed [COORD_WIDTH-1:0] corner_c_x;
    logic signed [COORD_WIDTH-1:0] corner_c_y;
    logic signed [COORD_WIDTH-1:0] corner_d_x;
    logic signed [COORD_WIDTH-1:0] corner_d_y;

    modport source (
        output valid, ref_x, ref_y, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
               corner_c_x, corner_c_y, corner_d_x, corner_d_y,
        input  ready
    );
    modport sink (
        input  valid, ref_x, ref_y, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
               corner_c_x, corner_c_y, corner_d_x, corner_d_y,
        output ready
    );
endinterface

interface qco_result_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_ref_x;
    logic signed [COORD_WIDTH-1:0] out_ref_y;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] fourth_x;
    logic signed [COORD_WIDTH-1:0] fourth_y;

    modport source (
        output valid, out_ref_x, out_ref_y, first_x, first_y, second_x, second_y,
               third_x, third_y, fourth_x, fourth_y,
        input  ready
    );
    modport sink (
        input  valid, out_ref_x, out_ref_y, first_x, first_y, second_x, second_y,
               third_x, third_y, fourth_x, fourth_y,
        output ready
    );
endinterface
`default_nettype wire

[sv/qco_center.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_center: centroid-relative corner vectors
// Registers v = 4*p - (sum of corners) for each corner; a corner on the
// centroid is moved to direction +x.
// ----------------------------------------------------------------------------
module qco_center #(
    parameter int COORD_WIDTH = 16,
    parameter int VW          = COORD_WIDTH + 3
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] px [qco_pkg::NCORNERS],
    input  logic signed [COORD_WIDTH-1:0] py [qco_pkg::NCORNERS],
    output logic signed [VW-1:0]          vx_reg [qco_pkg::NCORNERS],
    output logic signed [VW-1:0]          vy_reg [qco_pkg::NCORNERS]
);

    logic signed [VW-1:0] sx;
    logic signed [VW-1:0] sy;
    logic signed [VW-1:0] vx_next [qco_pkg::NCORNERS];
    logic signed [VW-1:0] vy_next [qco_pkg::NCORNERS];

    always_comb
    begin
        sx = '0;
        sy = '0;
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            sx = sx + VW'(px[k]);
            sy = sy + VW'(py[k]);
        end
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            vx_next[k] = (VW'(px[k]) <<< 2) - sx;
            vy_next[k] = (VW'(py[k]) <<< 2) - sy;
            // corner on the centroid counts as angle zero
            if (vx_next[k] == '0 && vy_next[k] == '0)
            begin
                vx_next[k] = VW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

endmodule
`default_nettype wire

[sv/qco_cross.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_cross: pairwise cross products and half-plane codes
// For each corner pair (i, j) registers vx[i]*vy[j] and vy[i]*vx[j], and the
// half-plane of every corner vector.
// ----------------------------------------------------------------------------
module qco_cross #(
    parameter int VW = 19
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [VW-1:0]  vx [qco_pkg::NCORNERS],
    input  logic signed [VW-1:0]  vy [qco_pkg::NCORNERS],
    output logic signed [2*VW-1:0] prod_a_reg [qco_pkg::NPAIRS],
    output logic signed [2*VW-1:0] prod_b_reg [qco_pkg::NPAIRS],
    output qco_pkg::half_t        half_reg [qco_pkg::NCORNERS]
);

    logic signed [2*VW-1:0] prod_a_next [qco_pkg::NPAIRS];
    logic signed [2*VW-1:0] prod_b_next [qco_pkg::NPAIRS];
    qco_pkg::half_t         half_next [qco_pkg::NCORNERS];

    always_comb
    begin
        for (int p = 0; p < qco_pkg::NPAIRS; p++)
        begin
            prod_a_next[p] = (2*VW)'(vx[qco_pkg::PAIR_I[p]]) * (2*VW)'(vy[qco_pkg::PAIR_J[p]]);
            prod_b_next[p] = (2*VW)'(vy[qco_pkg::PAIR_I[p]]) * (2*VW)'(vx[qco_pkg::PAIR_J[p]]);
        end
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            if (vy[k] < 0)
            begin
                half_next[k] = qco_pkg::HALF_LOWER;
            end
            else if (vy[k] > 0 || vx[k] >= 0)
            begin
                half_next[k] = qco_pkg::HALF_UPPER;
            end
            else
            begin
                half_next[k] = qco_pkg::HALF_PI;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            half_reg   <= half_next;
        end
    end

endmodule
`default_nettype wire

[sv/qco_rank.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_rank: stable angle ranking
// Builds the "comes before" relation from half-plane codes and cross
// products, and registers each corner's place in angle order. Equal angles
// keep input order.
// ----------------------------------------------------------------------------
module qco_rank #(
    parameter int VW = 19
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [2*VW-1:0] prod_a [qco_pkg::NPAIRS],
    input  logic signed [2*VW-1:0] prod_b [qco_pkg::NPAIRS],
    input  qco_pkg::half_t         half [qco_pkg::NCORNERS],
    output qco_pkg::idx_t          rank_reg [qco_pkg::NCORNERS]
);

    logic [qco_pkg::NCORNERS-1:0][qco_pkg::NCORNERS-1:0] ahead;
    logic [qco_pkg::IDX_W:0] rank_cnt [qco_pkg::NCORNERS];
    qco_pkg::idx_t           rank_next [qco_pkg::NCORNERS];

    always_comb
    begin
        qco_pkg::idx_t i;
        qco_pkg::idx_t j;
        ahead = '0;
        for (int p = 0; p < qco_pkg::NPAIRS; p++)
        begin
            i = qco_pkg::PAIR_I[p];
            j = qco_pkg::PAIR_J[p];
            if (half[i] != half[j])
            begin
                ahead[i][j] = (half[i] < half[j]);
                ahead[j][i] = (half[j] < half[i]);
            end
            else
            begin
                ahead[i][j] = (prod_a[p] > prod_b[p]);
                ahead[j][i] = (prod_a[p] < prod_b[p]);
            end
        end
        for (int a = 0; a < qco_pkg::NCORNERS; a++)
        begin
            rank_cnt[a] = '0;
            for (int b = 0; b < qco_pkg::NCORNERS; b++)
            begin
                // count corners strictly ahead, plus earlier inputs at equal angle
                if (b != a && (ahead[b][a] || (b < a && !ahead[a][b])))
                begin
                    rank_cnt[a] = rank_cnt[a] + 1'b1;
                end
            end
            rank_next[a] = rank_cnt[a][qco_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rank_reg <= rank_next;
        end
    end

endmodule
`default_nettype wire

[sv/qco_select.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_select: rotate the angle order and drive the result register
// Turns ranks into an order, picks the start corner with least x+y (first
// in order on a tie) and registers the rotated corners and reference point.
// ----------------------------------------------------------------------------
module qco_select #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  qco_pkg::idx_t                 rank [qco_pkg::NCORNERS],
    input  logic signed [COORD_WIDTH-1:0] px [qco_pkg::NCORNERS],
    input  logic signed [COORD_WIDTH-1:0] py [qco_pkg::NCORNERS],
    input  logic signed [COORD_WIDTH-1:0] ref_x,
    input  logic signed [COORD_WIDTH-1:0] ref_y,
    output logic signed [COORD_WIDTH-1:0] ref_x_reg,
    output logic signed [COORD_WIDTH-1:0] ref_y_reg,
    output logic signed [COORD_WIDTH-1:0] pos_x_reg [qco_pkg::NCORNERS],
    output logic signed [COORD_WIDTH-1:0] pos_y_reg [qco_pkg::NCORNERS]
);

    localparam int SW = COORD_WIDTH + 1;

    qco_pkg::idx_t                 order [qco_pkg::NCORNERS];
    logic signed [SW-1:0]          sum [qco_pkg::NCORNERS];
    logic signed [SW-1:0]          best;
    qco_pkg::idx_t                 start;
    logic signed [COORD_WIDTH-1:0] pos_x_next [qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] pos_y_next [qco_pkg::NCORNERS];

    always_comb
    begin
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            order[k] = '0;
        end
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            order[rank[k]] = qco_pkg::idx_t'(k);
        end
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            sum[k] = SW'(px[order[k]]) + SW'(py[order[k]]);
        end
        // strict compare keeps the earliest corner on equal sums
        start = '0;
        best  = sum[0];
        for (int k = 1; k < qco_pkg::NCORNERS; k++)
        begin
            if (sum[k] < best)
            begin
                best  = sum[k];
                start = qco_pkg::idx_t'(k);
            end
        end
        for (int k = 0; k < qco_pkg::NCORNERS; k++)
        begin
            pos_x_next[k] = px[order[start + qco_pkg::idx_t'(k)]];
            pos_y_next[k] = py[order[start + qco_pkg::idx_t'(k)]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ref_x_reg <= ref_x;
            ref_y_reg <= ref_y;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

endmodule
`default_nettype wire

[sv/quad_corner_order.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quad_corner_order: order the four corners of a quadrilateral by angle
// Sorts the corners by polar angle around their centroid and rotates the
// order to start at the corner with least x+y; the reference point passes.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload                                   handshake
//   quad      in          ref_x/y, corner_a..d_x/y                  valid/ready
//   result    out         out_ref_x/y, first..fourth_x/y            valid/ready
//
// Four register stages: centroid vectors, cross products, ranking, and the
// rotate/select stage that is the result register. One item per cycle
// while result is not stalled; an accepted item passes the stages in order.
// Reset clears the stage valid bits only. A stall on result holds every
// full stage; an empty stage still takes an item, so bubbles close up.
// ----------------------------------------------------------------------------
module quad_corner_order #(
    parameter int COORD_WIDTH = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    qco_quad_if.sink         quad,
    qco_result_if.source     result
);

    localparam int VW     = COORD_WIDTH + 3;
    localparam int NSTAGE = 3;

    // stage valid bits; stage 4 is the result register
    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic en1, en2, en3, en4;

    logic signed [COORD_WIDTH-1:0] in_px [qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] in_py [qco_pkg::NCORNERS];

    // corners and reference point carried alongside stages 1..3
    logic signed [COORD_WIDTH-1:0] px_reg [NSTAGE][qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] py_reg [NSTAGE][qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] ref_x_reg [NSTAGE];
    logic signed [COORD_WIDTH-1:0] ref_y_reg [NSTAGE];

    logic signed [VW-1:0]          vx [qco_pkg::NCORNERS];
    logic signed [VW-1:0]          vy [qco_pkg::NCORNERS];
    logic signed [2*VW-1:0]        prod_a [qco_pkg::NPAIRS];
    logic signed [2*VW-1:0]        prod_b [qco_pkg::NPAIRS];
    qco_pkg::half_t                half [qco_pkg::NCORNERS];
    qco_pkg::idx_t                 rank [qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] pos_x [qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] pos_y [qco_pkg::NCORNERS];
    logic signed [COORD_WIDTH-1:0] res_ref_x;
    logic signed [COORD_WIDTH-1:0] res_ref_y;

    // a stage loads when it is empty or its content moves on
    assign en4 = !valid4_reg || result.ready;
    assign en3 = !valid3_reg || en4;
    assign en2 = !valid2_reg || en3;
    assign en1 = !valid1_reg || en2;

    assign quad.ready   = en1;
    assign result.valid = valid4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                valid1_reg <= quad.valid;
            end
            if (en2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (en3)
            begin
                valid3_reg <= valid2_reg;
            end
            if (en4)
            begin
                valid4_reg <= valid3_reg;
            end
        end
    end

    assign in_px[0] = quad.corner_a_x;
    assign in_py[0] = quad.corner_a_y;
    assign in_px[1] = quad.corner_b_x;
    assign in_py[1] = quad.corner_b_y;
    assign in_px[2] = quad.corner_c_x;
    assign in_py[2] = quad.corner_c_y;
    assign in_px[3] = quad.corner_d_x;
    assign in_py[3] = quad.corner_d_y;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            px_reg[0]    <= in_px;
            py_reg[0]    <= in_py;
            ref_x_reg[0] <= quad.ref_x;
            ref_y_reg[0] <= quad.ref_y;
        end
        if (en2)
        begin
            px_reg[1]    <= px_reg[0];
            py_reg[1]    <= py_reg[0];
            ref_x_reg[1] <= ref_x_reg[0];
            ref_y_reg[1] <= ref_y_reg[0];
        end
        if (en3)
        begin
            px_reg[2]    <= px_reg[1];
            py_reg[2]    <= py_reg[1];
            ref_x_reg[2] <= ref_x_reg[1];
            ref_y_reg[2] <= ref_y_reg[1];
        end
    end

    qco_center #(
        .COORD_WIDTH (COORD_WIDTH),
        .VW          (VW)
    ) u_center (
        .clk    (clk),
        .en     (en1),
        .px     (in_px),
        .py     (in_py),
        .vx_reg (vx),
        .vy_reg (vy)
    );

    qco_cross #(
        .VW (VW)
    ) u_cross (
        .clk        (clk),
        .en         (en2),
        .vx         (vx),
        .vy         (vy),
        .prod_a_reg (prod_a),
        .prod_b_reg (prod_b),
        .half_reg   (half)
    );

    qco_rank #(
        .VW (VW)
    ) u_rank (
        .clk      (clk),
        .en       (en3),
        .prod_a   (prod_a),
        .prod_b   (prod_b),
        .half     (half),
        .rank_reg (rank)
    );

    qco_select #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_select (
        .clk       (clk),
        .en        (en4),
        .rank      (rank),
        .px        (px_reg[2]),
        .py        (py_reg[2]),
        .ref_x     (ref_x_reg[2]),
        .ref_y     (ref_y_reg[2]),
        .ref_x_reg (res_ref_x),
        .ref_y_reg (res_ref_y),
        .pos_x_reg (pos_x),
        .pos_y_reg (pos_y)
    );

    assign result.out_ref_x = res_ref_x;
    assign result.out_ref_y = res_ref_y;
    assign result.first_x   = pos_x[0];
    assign result.first_y   = pos_y[0];
    assign result.second_x  = pos_x[1];
    assign result.second_y  = pos_y[1];
    assign result.third_x   = pos_x[2];
    assign result.third_y   = pos_y[2];
    assign result.fourth_x  = pos_x[3];
    assign result.fourth_y  = pos_y[3];

endmodule
`default_nettype wire

[sv/qco_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_checker: port-level checks for quad_corner_order
// Tracks items in flight and checks occupancy, backpressure, result hold
// and the least-sum start corner.
// ----------------------------------------------------------------------------
module qco_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          quad_valid,
    input  wire                          quad_ready,
    input  wire                          result_valid,
    input  wire                          result_ready,
    input  wire signed [COORD_WIDTH-1:0] first_x,
    input  wire signed [COORD_WIDTH-1:0] first_y,
    input  wire signed [COORD_WIDTH-1:0] second_x,
    input  wire signed [COORD_WIDTH-1:0] second_y,
    input  wire signed [COORD_WIDTH-1:0] third_x,
    input  wire signed [COORD_WIDTH-1:0] third_y,
    input  wire signed [COORD_WIDTH-1:0] fourth_x,
    input  wire signed [COORD_WIDTH-1:0] fourth_y
);

    localparam int SW    = COORD_WIDTH + 1;
    localparam int DEPTH = 4;

    logic [2:0]           inflight_reg;
    logic [2:0]           inflight_next;
    logic                 acc_in;
    logic                 acc_out;
    logic signed [SW-1:0] sum_first;
    logic signed [SW-1:0] sum_second;
    logic signed [SW-1:0] sum_third;
    logic signed [SW-1:0] sum_fourth;

    assign acc_in  = quad_valid && quad_ready;
    assign acc_out = result_valid && result_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (acc_in && !acc_out)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (!acc_in && acc_out)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    assign sum_first  = SW'(first_x) + SW'(first_y);
    assign sum_second = SW'(second_x) + SW'(second_y);
    assign sum_third  = SW'(third_x) + SW'(third_y);
    assign sum_fourth = SW'(fourth_x) + SW'(fourth_y);

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'(DEPTH))
        else $error("more items in flight than pipeline stages");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != '0)
        else $error("result shown with no item in flight");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !quad_ready |-> (result_valid && !result_ready))
        else $error("input stalled while output is not blocked");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(first_x) && $stable(first_y)
             && $stable(fourth_x) && $stable(fourth_y)))
        else $error("stalled result changed");

    a_start_least_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (sum_first <= sum_second && sum_first <= sum_third
                          && sum_first <= sum_fourth))
        else $error("first corner does not have the least x+y");

endmodule

bind quad_corner_order qco_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_qco_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .quad_valid   (quad.valid),
    .quad_ready   (quad.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .first_x      (result.first_x),
    .first_y      (result.first_y),
    .second_x     (result.second_x),
    .second_y     (result.second_y),
    .third_x      (result.third_x),
    .third_y      (result.third_y),
    .fourth_x     (result.fourth_x),
    .fourth_y     (result.fourth_y)
);
`default_nettype wire
